>>> rtl/rgt_pkg.sv
// ----------------------------------------------------------------------------
// rgt_pkg
// Shared widths, register indexes and the configuration bundle for the
// rgb gradient tween unit.
// ----------------------------------------------------------------------------
package rgt_pkg;

   localparam int CHANNEL_BITS  = 8;
   localparam int FRACTION_BITS = 10;
   localparam int STEP_BITS     = CHANNEL_BITS + FRACTION_BITS;
   localparam int PROD_BITS     = CHANNEL_BITS + STEP_BITS;
   localparam int NUM_CHANNELS  = 3;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 8;

   localparam logic [CSR_IDX_BITS-1:0] REG_START_RED   = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_START_GREEN = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_START_BLUE  = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_END_RED     = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_END_GREEN   = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_END_BLUE    = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] REG_STEP_COUNT  = 3'd6;

   localparam logic [CHANNEL_BITS-1:0] STEP_COUNT_RESET = CHANNEL_BITS'(2);

   typedef logic [CHANNEL_BITS-1:0] chan_type;
   typedef logic [STEP_BITS-1:0]    step_type;

   typedef struct packed {
      chan_type [NUM_CHANNELS-1:0] start_color;
      chan_type [NUM_CHANNELS-1:0] end_color;
      chan_type                    step_count;
      step_type [NUM_CHANNELS-1:0] step;
      logic     [NUM_CHANNELS-1:0] rising;
   } tween_cfg_type;

endpackage

>>> rtl/rgt_if.sv
// ----------------------------------------------------------------------------
// rgt_if
// Valid/ready channels for gradient positions and interpolated colors.
// ----------------------------------------------------------------------------
interface rgt_req_if
   import rgt_pkg::*;
   ();
   logic     valid;
   logic     ready;
   chan_type position;

   modport source (output valid, output position, input ready);
   modport sink   (input valid, input position, output ready);
endinterface

interface rgt_rsp_if
   import rgt_pkg::*;
   ();
   logic     valid;
   logic     ready;
   chan_type red;
   chan_type green;
   chan_type blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

>>> rtl/rgb_gradient_tween_unit.sv
// ----------------------------------------------------------------------------
// rgb_gradient_tween_unit
// Linear rgb gradient: color registers, per-channel step divider and the
// interpolation pipeline.
// an accepted position beat passes stage 1, stage 2 and the output register
// throughput: one position per cycle, set by the three-stage pipeline, unless a stall holds it
// after a register write the step divider runs, and until it is done
// req_chan.ready stays low
// reset: synchronous; colors 0, step_count 2, steps 0, pipeline empty
// ----------------------------------------------------------------------------
module rgb_gradient_tween_unit
   import rgt_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_en,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_write_data,
   rgt_req_if.sink                  req_chan,
   rgt_rsp_if.source                rsp_chan
);

   chan_type [NUM_CHANNELS-1:0] start_ff, start_in;
   chan_type [NUM_CHANNELS-1:0] end_ff, end_in;
   chan_type                    count_ff, count_in;
   logic                        pend_ff, pend_in;

   logic                        div_busy;
   step_type [NUM_CHANNELS-1:0] step;
   logic     [NUM_CHANNELS-1:0] rising;
   tween_cfg_type               cfg;

   always_comb begin
      start_in = start_ff;
      end_in   = end_ff;
      count_in = count_ff;
      pend_in  = 1'b0;
      if (csr_write_en) begin
         pend_in = 1'b1;
         case (csr_index)
            REG_START_RED:   start_in[0] = csr_write_data[CHANNEL_BITS-1:0];
            REG_START_GREEN: start_in[1] = csr_write_data[CHANNEL_BITS-1:0];
            REG_START_BLUE:  start_in[2] = csr_write_data[CHANNEL_BITS-1:0];
            REG_END_RED:     end_in[0]   = csr_write_data[CHANNEL_BITS-1:0];
            REG_END_GREEN:   end_in[1]   = csr_write_data[CHANNEL_BITS-1:0];
            REG_END_BLUE:    end_in[2]   = csr_write_data[CHANNEL_BITS-1:0];
            REG_STEP_COUNT:  count_in    = csr_write_data[CHANNEL_BITS-1:0];
            default:         pend_in     = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         end_ff   <= '0;
         count_ff <= STEP_COUNT_RESET;
         pend_ff  <= 1'b0;
      end else begin
         start_ff <= start_in;
         end_ff   <= end_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   rgt_step_div u_step_div (
      .clock       (clock),
      .reset       (reset),
      .start       (pend_ff),
      .start_color (start_ff),
      .end_color   (end_ff),
      .step_count  (count_ff),
      .busy        (div_busy),
      .step        (step),
      .rising      (rising)
   );

   always_comb begin
      cfg.start_color = start_ff;
      cfg.end_color   = end_ff;
      cfg.step_count  = count_ff;
      cfg.step        = step;
      cfg.rising      = rising;
   end

   rgt_interp_pipe u_interp_pipe (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .hold     (div_busy || pend_in),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule

>>> rtl/rgt_step_div.sv
// ----------------------------------------------------------------------------
// rgt_step_div
// Restoring divider, one quotient bit per cycle, for the three channel
// steps floor(|end-start| * 2^FRACTION_BITS / (step_count-1)).
// ----------------------------------------------------------------------------
module rgt_step_div
   import rgt_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  chan_type [NUM_CHANNELS-1:0]   start_color,
   input  chan_type [NUM_CHANNELS-1:0]   end_color,
   input  chan_type                      step_count,
   output logic                          busy,
   output step_type [NUM_CHANNELS-1:0]   step,
   output logic     [NUM_CHANNELS-1:0]   rising
);

   localparam int CNT_BITS = $clog2(STEP_BITS + 1);

   step_type [NUM_CHANNELS-1:0] dq_ff, dq_in;
   chan_type [NUM_CHANNELS-1:0] rem_ff, rem_in;
   logic     [NUM_CHANNELS-1:0] rising_ff, rising_in;
   chan_type                    div_ff, div_in;
   logic     [CNT_BITS-1:0]     left_ff, left_in;

   logic [CHANNEL_BITS:0] trial;
   logic                  qbit;
   chan_type              diff;

   always_comb begin
      dq_in     = dq_ff;
      rem_in    = rem_ff;
      rising_in = rising_ff;
      div_in    = div_ff;
      left_in   = left_ff;
      trial     = '0;
      qbit      = 1'b0;
      diff      = '0;
      if (start) begin
         // count below two: zero dividend over all-ones divisor gives step 0
         div_in  = (step_count < STEP_COUNT_RESET) ? '1 : step_count - CHANNEL_BITS'(1);
         left_in = CNT_BITS'(STEP_BITS);
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            if (end_color[c] >= start_color[c]) begin
               rising_in[c] = 1'b1;
               diff         = end_color[c] - start_color[c];
            end else begin
               rising_in[c] = 1'b0;
               diff         = start_color[c] - end_color[c];
            end
            if (step_count < STEP_COUNT_RESET) begin
               diff = '0;
            end
            dq_in[c]  = {diff, {FRACTION_BITS{1'b0}}};
            rem_in[c] = '0;
         end
      end else if (left_ff != '0) begin
         left_in = left_ff - CNT_BITS'(1);
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            trial = {rem_ff[c], dq_ff[c][STEP_BITS-1]};
            qbit  = (trial >= {1'b0, div_ff});
            if (qbit) begin
               trial = trial - {1'b0, div_ff};
            end
            rem_in[c] = trial[CHANNEL_BITS-1:0];
            dq_in[c]  = {dq_ff[c][STEP_BITS-2:0], qbit};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dq_ff     <= '0;
         rem_ff    <= '0;
         rising_ff <= '1;
         div_ff    <= '1;
         left_ff   <= '0;
      end else begin
         dq_ff     <= dq_in;
         rem_ff    <= rem_in;
         rising_ff <= rising_in;
         div_ff    <= div_in;
         left_ff   <= left_in;
      end
   end

   assign busy   = start || (left_ff != '0);
   assign step   = dq_ff;
   assign rising = rising_ff;

endmodule

>>> rtl/rgt_interp_pipe.sv
// ----------------------------------------------------------------------------
// rgt_interp_pipe
// Three-stage interpolation pipeline: position decode, step multiply,
// add or subtract and end point select into the output register.
// ----------------------------------------------------------------------------
module rgt_interp_pipe
   import rgt_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  tween_cfg_type  cfg,
   input  logic           hold,
   rgt_req_if.sink        req_chan,
   rgt_rsp_if.source      rsp_chan
);

   typedef enum logic [1:0] {
      PICK_START,
      PICK_END,
      PICK_INTERP
   } pick_type;

   logic en1, en2, en3, accept;

   // stage 1
   logic     v1_ff, v1_in;
   chan_type pos_ff, pos_in;
   pick_type pick1_ff, pick1_in;

   // stage 2
   logic                        v2_ff, v2_in;
   pick_type                    pick2_ff, pick2_in;
   chan_type [NUM_CHANNELS-1:0] delta_ff, delta_in;
   logic     [PROD_BITS-1:0]    prod;

   // stage 3 (output)
   logic                        v3_ff, v3_in;
   chan_type [NUM_CHANNELS-1:0] color_ff, color_in;

   assign en3    = !v3_ff || rsp_chan.ready;
   assign en2    = !v2_ff || en3;
   assign en1    = !v1_ff || en2;
   assign accept = req_chan.valid && req_chan.ready;

   assign req_chan.ready = en1 && !hold;

   always_comb begin
      v1_in    = accept;
      pos_in   = req_chan.position;
      pick1_in = PICK_INTERP;
      if (req_chan.position == '0) begin
         pick1_in = PICK_START;
      end else if (cfg.step_count < STEP_COUNT_RESET ||
                   req_chan.position >= cfg.step_count - CHANNEL_BITS'(1)) begin
         pick1_in = PICK_END;
      end
   end

   always_comb begin
      v2_in    = v1_ff;
      pick2_in = pick1_ff;
      prod     = '0;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         prod        = PROD_BITS'(pos_ff) * PROD_BITS'(cfg.step[c]);
         delta_in[c] = prod[FRACTION_BITS +: CHANNEL_BITS];
      end
   end

   always_comb begin
      v3_in = v2_ff;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         case (pick2_ff)
            PICK_START:  color_in[c] = cfg.start_color[c];
            PICK_END:    color_in[c] = cfg.end_color[c];
            PICK_INTERP: color_in[c] = cfg.rising[c] ? cfg.start_color[c] + delta_ff[c]
                                                     : cfg.start_color[c] - delta_ff[c];
            default:     color_in[c] = cfg.start_color[c];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= v1_in;
         end
         if (en2) begin
            v2_ff <= v2_in;
         end
         if (en3) begin
            v3_ff <= v3_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         pos_ff   <= pos_in;
         pick1_ff <= pick1_in;
      end
      if (en2) begin
         pick2_ff <= pick2_in;
         delta_ff <= delta_in;
      end
      if (en3) begin
         color_ff <= color_in;
      end
   end

   assign rsp_chan.valid = v3_ff;
   assign rsp_chan.red   = color_ff[0];
   assign rsp_chan.green = color_ff[1];
   assign rsp_chan.blue  = color_ff[2];

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the rgb gradient tween unit against a local gradient predictor.
// Gradients are loaded over the register port while the unit is idle, then
// positions are streamed in with random gaps and result stalls; every color
// beat is compared channel by channel against the predicted color.
// ----------------------------------------------------------------------------
module testbench;
   import rgt_pkg::*;

   localparam logic [CSR_IDX_BITS-1:0] REG_UNUSED = 3'd7;
   localparam int IDLE_LIMIT   = 1000;
   localparam int LONG_HOLD    = 64;
   localparam int HOLD_AT_BEAT = 400;

   typedef struct packed {
      chan_type                    position;
      chan_type [NUM_CHANNELS-1:0] level;
   } color_type;

   logic                     clock;
   logic                     reset;
   logic                     csr_write_en;
   logic [CSR_IDX_BITS-1:0]  csr_index;
   logic [CSR_DATA_BITS-1:0] csr_write_data;

   rgt_req_if req_chan ();
   rgt_rsp_if rsp_chan ();

   rgb_gradient_tween_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan)
   );

   // gradient state as the unit should hold it
   chan_type              start_level [NUM_CHANNELS];
   chan_type              end_level   [NUM_CHANNELS];
   chan_type              gradient_steps;
   step_type              level_step  [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] level_rising;

   chan_type  position_queue [$];
   color_type due_colors [$];
   string     channel_label [NUM_CHANNELS] = '{"red", "green", "blue"};

   int  issued_count   = 0;
   int  accepted_count = 0;
   int  colors_checked = 0;
   int  mismatch_count = 0;
   int  idle_cycles    = 0;
   int  send_gap       = 0;
   int  take_gap       = 0;
   int  long_hold      = 0;
   bit  hold_done      = 0;
   bit  quiet_tail     = 0;
   bit  req_beat       = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic void refresh_steps();
      chan_type diff;
      level_rising = '0;
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
         if (end_level[ch] >= start_level[ch]) begin
            level_rising[ch] = 1'b1;
            diff = end_level[ch] - start_level[ch];
         end else begin
            diff = start_level[ch] - end_level[ch];
         end
         if (gradient_steps >= 2)
            level_step[ch] = STEP_BITS'((32'(diff) << FRACTION_BITS) /
                                        (32'(gradient_steps) - 1));
         else
            level_step[ch] = '0;
      end
   endfunction

   function automatic color_type interpolate_color(chan_type position);
      color_type             c;
      logic [PROD_BITS-1:0]  product;
      chan_type              delta;
      c.position = position;
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
         if (position == 0) begin
            c.level[ch] = start_level[ch];
         end else if (gradient_steps < 2 || 32'(position) >= 32'(gradient_steps) - 1) begin
            c.level[ch] = end_level[ch];
         end else begin
            product = PROD_BITS'(position) * PROD_BITS'(level_step[ch]);
            delta   = chan_type'(product >> FRACTION_BITS);
            c.level[ch] = level_rising[ch] ? start_level[ch] + delta
                                           : start_level[ch] - delta;
         end
      end
      return c;
   endfunction

   task automatic put_register(input logic [CSR_IDX_BITS-1:0] index, input chan_type data);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= index;
      csr_write_data <= data;
      case (index)
         REG_START_RED:   start_level[0] = data;
         REG_START_GREEN: start_level[1] = data;
         REG_START_BLUE:  start_level[2] = data;
         REG_END_RED:     end_level[0]   = data;
         REG_END_GREEN:   end_level[1]   = data;
         REG_END_BLUE:    end_level[2]   = data;
         REG_STEP_COUNT:  gradient_steps = data;
         default: ;
      endcase
      refresh_steps();
   endtask

   task automatic load_gradient(input chan_type sr, input chan_type sg, input chan_type sb,
                                input chan_type er, input chan_type eg, input chan_type eb,
                                input chan_type count, input bit poke_unused);
      put_register(REG_STEP_COUNT, count);
      put_register(REG_START_RED, sr);
      put_register(REG_START_GREEN, sg);
      put_register(REG_START_BLUE, sb);
      put_register(REG_END_RED, er);
      put_register(REG_END_GREEN, eg);
      put_register(REG_END_BLUE, eb);
      if (poke_unused)
         put_register(REG_UNUSED, chan_type'($urandom));
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic queue_position(input chan_type position);
      position_queue.insert(position_queue.size(), position);
      issued_count++;
   endtask

   task automatic wait_for_drain();
      while (accepted_count != issued_count || due_colors.size() != 0)
         @(negedge clock);
   endtask

   function automatic chan_type pick_level();
      case ($urandom_range(0, 5))
         0: return 8'd0;
         1: return 8'd255;
         default: return chan_type'($urandom);
      endcase
   endfunction

   task automatic load_random_gradient(input bit poke_unused);
      chan_type s [NUM_CHANNELS];
      chan_type e [NUM_CHANNELS];
      chan_type count;
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
         s[ch] = pick_level();
         e[ch] = ($urandom_range(0, 5) == 0) ? s[ch] : pick_level();
      end
      case ($urandom_range(0, 7))
         0: count = 8'd2;
         1: count = 8'd3;
         2: count = 8'd255;
         3: count = 8'd254;
         4: count = chan_type'($urandom_range(2, 16));
         default: count = chan_type'($urandom_range(2, 255));
      endcase
      load_gradient(s[0], s[1], s[2], e[0], e[1], e[2], count, poke_unused);
   endtask

   task automatic queue_random_positions(input int n);
      chan_type position;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 11))
            0: position = 8'd0;
            1: position = gradient_steps - 8'd1;
            2: position = gradient_steps - 8'd2;
            3: position = gradient_steps;
            4: position = 8'd255;
            5, 6: position = chan_type'($urandom);
            default: position = chan_type'($urandom_range(0, gradient_steps));
         endcase
         queue_position(position);
      end
   endtask

   // position driver
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid    <= 1'b0;
         req_chan.position <= '0;
      end else if (!req_chan.valid || req_beat) begin
         if (send_gap > 0) begin
            req_chan.valid <= 1'b0;
            send_gap--;
         end else if (position_queue.size() == 0) begin
            req_chan.valid <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            req_chan.valid <= 1'b0;
            send_gap = $urandom_range(0, 6);
         end else begin
            req_chan.valid    <= 1'b1;
            req_chan.position <= position_queue.pop_front();
         end
      end
   end

   // color receiver
   always @(negedge clock) begin
      if (!hold_done && colors_checked >= HOLD_AT_BEAT) begin
         hold_done = 1;
         long_hold = LONG_HOLD;
      end
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (long_hold > 0) begin
         rsp_chan.ready <= 1'b0;
         long_hold--;
      end else if (take_gap > 0) begin
         rsp_chan.ready <= 1'b0;
         take_gap--;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
         rsp_chan.ready <= 1'b0;
         take_gap = $urandom_range(0, 6);
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // beat monitor, color check and watchdog
   always @(posedge clock) begin
      color_type              want;
      chan_type [NUM_CHANNELS-1:0] seen;
      bit                     rsp_beat;
      req_beat = !reset && req_chan.valid && req_chan.ready;
      rsp_beat = !reset && rsp_chan.valid && rsp_chan.ready;
      if (req_beat) begin
         due_colors.insert(due_colors.size(), interpolate_color(req_chan.position));
         accepted_count++;
      end
      if (rsp_beat) begin
         seen = {rsp_chan.blue, rsp_chan.green, rsp_chan.red};
         if (due_colors.size() == 0) begin
            $display("%0t: unexpected color beat %02x %02x %02x", $time,
                     rsp_chan.red, rsp_chan.green, rsp_chan.blue);
            mismatch_count++;
         end else begin
            want = due_colors.pop_front();
            for (int ch = 0; ch < NUM_CHANNELS; ch++)
               if (seen[ch] !== want.level[ch]) begin
                  $display("%0t: %s mismatch at position %0d: expected %02x, got %02x",
                           $time, channel_label[ch], want.position, want.level[ch],
                           seen[ch]);
                  mismatch_count++;
               end
         end
         colors_checked++;
      end
      if (reset || req_beat || rsp_beat)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      reset             = 1'b1;
      csr_write_en      = 1'b0;
      csr_index         = '0;
      csr_write_data    = '0;
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
         start_level[ch] = '0;
         end_level[ch]   = '0;
      end
      gradient_steps = STEP_COUNT_RESET;
      refresh_steps();
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // reset gradient
      queue_position(8'd0);
      queue_position(8'd1);
      queue_position(8'd2);
      queue_position(8'd255);
      wait_for_drain();

      // full swing both ways over the longest gradient
      load_gradient(8'd0, 8'd255, 8'd100, 8'd255, 8'd0, 8'd100, 8'd255, 1'b0);
      queue_position(8'd0);
      queue_position(8'd1);
      queue_position(8'd2);
      queue_position(8'd85);
      queue_position(8'd127);
      queue_position(8'd128);
      queue_position(8'd170);
      queue_position(8'd253);
      queue_position(8'd254);
      queue_position(8'd255);
      wait_for_drain();

      // three-point gradient, positions past the end
      load_gradient(8'd255, 8'd0, 8'd7, 8'd0, 8'd255, 8'd200, 8'd3, 1'b0);
      queue_position(8'd0);
      queue_position(8'd1);
      queue_position(8'd2);
      queue_position(8'd3);
      queue_position(8'd255);
      wait_for_drain();

      // shortest gradient, one channel with equal ends, unused index
      load_gradient(8'd9, 8'd9, 8'd9, 8'd9, 8'd200, 8'd3, 8'd2, 1'b1);
      queue_position(8'd0);
      queue_position(8'd1);
      queue_position(8'd128);
      wait_for_drain();

      for (int phase = 0; phase < 30; phase++) begin
         load_random_gradient(phase % 8 == 3);
         queue_random_positions(52);
         wait_for_drain();
      end

      quiet_tail = 1;
      load_random_gradient(1'b0);
      queue_random_positions(100);
      wait_for_drain();
      repeat (8) @(negedge clock);

      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
